@@ rtl/hscc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hscc_pkg
// Shared types, constants and CRC helper for the humidity sensor check and
// conversion block.
// ----------------------------------------------------------------------------
package hscc_pkg;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_READY = 2'd1,
        STATUS_CRC_ERROR = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_LOW_RES  = 2'd0,
        REG_TEMP_CMD = 2'd1,
        REG_HUM_CMD  = 2'd2
    } reg_index_t;

    localparam int unsigned APB_ADDR_W          = 4;
    localparam int unsigned APB_DATA_W          = 32;
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [7:0]  CRC_POLY      = 8'h31;
    localparam logic [7:0]  CRC_SEED_LOW  = 8'h80;
    localparam logic [7:0]  CRC_SEED_HIGH = 8'h00;
    localparam logic [7:0]  TEMP_CMD_RST  = 8'd3;
    localparam logic [7:0]  HUM_CMD_RST   = 8'd5;

    localparam logic [15:0] TEMP_OFFSET   = 16'd4000;
    localparam logic [15:0] HUM_OFFSET    = 16'd400;
    localparam logic [31:0] HUM_C2        = 32'd1087163596;
    localparam logic [31:0] HUM_C3_LOW    = 32'hFFED_9169;  // -1207959
    localparam logic [31:0] HUM_C3_HIGH   = 32'hFFFB_6999;  // -300647
    localparam logic [31:0] HUM_ROUND     = 32'h0001_0000;

    typedef struct packed {
        logic       low_res;
        logic [7:0] temp_cmd;
        logic [7:0] hum_cmd;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic        low_res;
        status_t     status;
        logic [15:0] raw;
    } item_t;

    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        logic       top;
        c = crc;
        d = data;
        for (int i = 0; i < 8; i++)
        begin
            top = c[7] ^ d[7];
            c   = {c[6:0], 1'b0};
            if (top)
            begin
                c = c ^ CRC_POLY;
            end
            d = {d[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/hscc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hscc_front
// Accepts requests, runs the CRC one byte per stage and classifies each
// request as ok, not ready or CRC error before pushing it to the queue.
// ----------------------------------------------------------------------------
module hscc_front
    import hscc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       accept,
    input  wire logic       kind,
    input  wire logic       sensor_ready,
    input  wire logic [7:0] data_high,
    input  wire logic [7:0] data_low,
    input  wire logic [7:0] check_byte,
    output logic [1:0]      in_flight,
    output logic            push,
    output item_t           push_item
);

    logic       a_valid_reg;
    logic       a_kind_reg;
    logic       a_ready_reg;
    logic       a_low_res_reg;
    logic [7:0] a_hi_reg;
    logic [7:0] a_lo_reg;
    logic [7:0] a_chk_reg;
    logic [7:0] a_crc_reg;

    logic       b_valid_reg;
    logic       b_kind_reg;
    logic       b_ready_reg;
    logic       b_low_res_reg;
    logic [7:0] b_hi_reg;
    logic [7:0] b_lo_reg;
    logic [7:0] b_chk_reg;
    logic [7:0] b_crc_reg;

    logic [7:0] seed;
    logic [7:0] cmd;
    logic [7:0] a_crc_next;
    logic [7:0] b_crc_next;
    logic [7:0] crc_final;

    assign seed       = cfg.low_res ? CRC_SEED_LOW : CRC_SEED_HIGH;
    assign cmd        = kind ? cfg.hum_cmd : cfg.temp_cmd;
    assign a_crc_next = crc_feed(seed, cmd);
    assign b_crc_next = crc_feed(a_crc_reg, a_hi_reg);
    assign crc_final  = crc_feed(b_crc_reg, b_lo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_kind_reg    <= kind;
        a_ready_reg   <= sensor_ready;
        a_low_res_reg <= cfg.low_res;
        a_hi_reg      <= data_high;
        a_lo_reg      <= data_low;
        a_chk_reg     <= check_byte;
        a_crc_reg     <= a_crc_next;

        b_kind_reg    <= a_kind_reg;
        b_ready_reg   <= a_ready_reg;
        b_low_res_reg <= a_low_res_reg;
        b_hi_reg      <= a_hi_reg;
        b_lo_reg      <= a_lo_reg;
        b_chk_reg     <= a_chk_reg;
        b_crc_reg     <= b_crc_next;
    end

    always_comb
    begin
        push_item.kind    = b_kind_reg;
        push_item.low_res = b_low_res_reg;
        push_item.raw     = {b_hi_reg, b_lo_reg};
        if (!b_ready_reg)
        begin
            push_item.status = STATUS_NOT_READY;
        end
        else if (crc_final != b_chk_reg)
        begin
            push_item.status = STATUS_CRC_ERROR;
        end
        else
        begin
            push_item.status = STATUS_OK;
        end
    end

    assign push      = b_valid_reg;
    assign in_flight = {1'b0, a_valid_reg} + {1'b0, b_valid_reg};

    a_front_flow: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> a_valid_reg ##1 push)
        else $error("front stage lost a request");

endmodule
`default_nettype wire

@@ rtl/hscc_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hscc_queue
// Small FIFO of classified requests between the front and back parts.
// ----------------------------------------------------------------------------
module hscc_queue
    import hscc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire item_t                      push_item,
    input  wire logic                       pop,
    output item_t                           pop_item,
    output logic                            empty,
    output logic [$clog2(DEPTH + 1) - 1:0]  count
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    item_t             store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              full;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item = store_reg[rd_ptr_reg];
    assign count    = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue overflow");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop && !full) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count out of step");

endmodule
`default_nettype wire

@@ rtl/hscc_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hscc_back
// Conversion pipeline: temperature offset or the humidity fixed-point
// polynomial, with multipliers in the first and third stages, then the registered result.
// ----------------------------------------------------------------------------
module hscc_back
    import hscc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    input  wire item_t  in_item,
    output logic        done,
    output logic [15:0] value,
    output logic [1:0]  status
);

    logic        v1_reg;
    item_t       it1_reg;
    logic [31:0] p1_reg;
    logic        v2_reg;
    item_t       it2_reg;
    logic [31:0] s2_reg;
    logic        v3_reg;
    item_t       it3_reg;
    logic [31:0] p3_reg;
    logic        done_reg;
    logic [15:0] value_reg;
    logic [15:0] value_next;
    status_t     status_reg;

    logic [31:0] raw_in;
    logic [31:0] raw2;
    logic [31:0] c3;
    logic [31:0] t2;
    logic [31:0] s2_next;
    logic [31:0] hum_shift;
    logic [15:0] temp_val;

    assign raw_in = {{16{in_item.raw[15]}}, in_item.raw};
    assign raw2   = {{16{it2_reg.raw[15]}}, it2_reg.raw};
    assign c3     = in_item.low_res ? HUM_C3_LOW : HUM_C3_HIGH;

    always_comb
    begin
        if (it1_reg.low_res)
        begin
            t2      = p1_reg + HUM_C2;
            s2_next = 32'($signed(t2) >>> 7);
        end
        else
        begin
            t2      = 32'($signed(p1_reg) >>> 2) + HUM_C2;
            s2_next = 32'($signed(t2) >>> 11);
        end
    end

    assign hum_shift = 32'($signed(p3_reg) >>> 17);
    assign temp_val  = it3_reg.low_res ? ({it3_reg.raw[13:0], 2'b00} - TEMP_OFFSET)
                                       : (it3_reg.raw - TEMP_OFFSET);

    always_comb
    begin
        if (it3_reg.status != STATUS_OK)
        begin
            value_next = '0;
        end
        else if (!it3_reg.kind)
        begin
            value_next = temp_val;
        end
        else
        begin
            value_next = hum_shift[15:0] - HUM_OFFSET;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        it1_reg    <= in_item;
        p1_reg     <= 32'(c3 * raw_in);
        it2_reg    <= it1_reg;
        s2_reg     <= s2_next;
        it3_reg    <= it2_reg;
        p3_reg     <= 32'(s2_reg * raw2) + HUM_ROUND;
        value_reg  <= value_next;
        status_reg <= it3_reg.status;
    end

    assign done   = done_reg;
    assign value  = value_reg;
    assign status = status_reg;

    a_zero_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg != STATUS_OK)) |-> (value_reg == '0))
        else $error("faulted result carries a nonzero value");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |=> v1_reg ##1 v2_reg ##1 v3_reg ##1 done_reg)
        else $error("back pipeline dropped a request");

endmodule
`default_nettype wire

@@ rtl/humidity_sensor_check_convert.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_sensor_check_convert
// CRC-8 check and conversion of one humidity/temperature sensor reading.
// ----------------------------------------------------------------------------
// One request is taken per clock while busy is low. Each result appears for a
// single cycle with done high, after its request passes two CRC stages of
// one byte each in the front part, a registered pass through the request queue
// and four conversion stages built around two 32-bit multipliers. The back
// part never stalls, so busy only rises if the queue could overflow. Results
// must be taken when done is high; there is no way to hold them off.
// ----------------------------------------------------------------------------
module humidity_sensor_check_convert
    import hscc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  kind,
    input  wire logic                  sensor_ready,
    input  wire logic [7:0]            data_high,
    input  wire logic [7:0]            data_low,
    input  wire logic [7:0]            check_byte,
    output logic                       done,
    output logic signed [15:0]         value,
    output logic [1:0]                 status
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic        low_res_reg;
    logic [7:0]  temp_cmd_reg;
    logic [7:0]  hum_cmd_reg;
    cfg_t        cfg;
    logic        wr_en;
    reg_index_t  reg_sel;

    logic             accept;
    logic [1:0]       in_flight;
    logic             push;
    item_t            push_item;
    item_t            pop_item;
    logic             q_empty;
    logic [CNT_W-1:0] q_count;
    logic [CNT_W+1:0] occupancy;
    logic [15:0]      value_raw;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_res_reg  <= 1'b0;
            temp_cmd_reg <= TEMP_CMD_RST;
            hum_cmd_reg  <= HUM_CMD_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_LOW_RES:  low_res_reg  <= pwdata[0];
                REG_TEMP_CMD: temp_cmd_reg <= pwdata[7:0];
                REG_HUM_CMD:  hum_cmd_reg  <= pwdata[7:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_LOW_RES:  prdata = {{(APB_DATA_W-1){1'b0}}, low_res_reg};
            REG_TEMP_CMD: prdata = {{(APB_DATA_W-8){1'b0}}, temp_cmd_reg};
            REG_HUM_CMD:  prdata = {{(APB_DATA_W-8){1'b0}}, hum_cmd_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg.low_res  = low_res_reg;
    assign cfg.temp_cmd = temp_cmd_reg;
    assign cfg.hum_cmd  = hum_cmd_reg;

    assign occupancy = {2'b00, q_count} + {{CNT_W{1'b0}}, in_flight};
    assign busy      = (occupancy >= (CNT_W + 2)'(QUEUE_DEPTH));
    assign accept    = start && !busy;

    hscc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .accept       (accept),
        .kind         (kind),
        .sensor_ready (sensor_ready),
        .data_high    (data_high),
        .data_low     (data_low),
        .check_byte   (check_byte),
        .in_flight    (in_flight),
        .push         (push),
        .push_item    (push_item)
    );

    hscc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (!q_empty),
        .pop_item  (pop_item),
        .empty     (q_empty),
        .count     (q_count)
    );

    hscc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!q_empty),
        .in_item  (pop_item),
        .done     (done),
        .value    (value_raw),
        .status   (status)
    );

    assign value = $signed(value_raw);

endmodule
`default_nettype wire

@@ verif/tb_humidity_sensor_check_convert.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_humidity_sensor_check_convert
// Self-checking bench for the sensor reading CRC check and unit conversion.
// Directed requests are followed by random bursts. Each accepted request is
// run through a local CRC-8 and fixed-point predictor, and every done strobe
// is matched against the oldest prediction. The APB registers are rewritten
// between phases, covering both resolutions and extreme command bytes.
// ----------------------------------------------------------------------------
module tb_humidity_sensor_check_convert;
    import hscc_pkg::*;

    localparam int         STALL_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 12;
    localparam logic [7:0] POLY_31      = 8'h31;
    localparam int         T_OFFSET     = 4000;
    localparam int         H_OFFSET     = 400;
    localparam int         H_C2         = 1087163596;
    localparam int         H_C3_LOWRES  = -1207959;
    localparam int         H_C3_HIGHRES = -300647;
    localparam int         H_ROUND      = 65536;

    typedef struct {
        logic [15:0] value;
        status_t     status;
    } reading_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  start;
    logic                  busy;
    logic                  kind;
    logic                  sensor_ready;
    logic [7:0]            data_high;
    logic [7:0]            data_low;
    logic [7:0]            check_byte;
    logic                  done;
    logic signed [15:0]    value;
    logic [1:0]            status;

    cfg_t                  model_cfg;
    reading_result_t       expected_readings[$];
    int                    error_count;
    int                    stall_cycles;

    humidity_sensor_check_convert uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .sensor_ready (sensor_ready),
        .data_high    (data_high),
        .data_low     (data_low),
        .check_byte   (check_byte),
        .done         (done),
        .value        (value),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // CRC-8 over command, high and low byte, MSB first
    function automatic logic [7:0] reading_crc(input logic k, input logic [7:0] hi,
                                               input logic [7:0] lo);
        logic [23:0] stream;
        logic [7:0]  crc;
        logic        fb;
        stream = {(k ? model_cfg.hum_cmd : model_cfg.temp_cmd), hi, lo};
        crc    = model_cfg.low_res ? 8'h80 : 8'h00;
        for (int i = 23; i >= 0; i--)
        begin
            fb  = crc[7] ^ stream[i];
            crc = {crc[6:0], 1'b0} ^ (fb ? POLY_31 : 8'h00);
        end
        return crc;
    endfunction

    function automatic reading_result_t convert_reading(input logic k, input logic rdy,
                                                        input logic [7:0] hi,
                                                        input logic [7:0] lo,
                                                        input logic [7:0] chk);
        reading_result_t res;
        int              raw;
        int              acc;
        res.value = '0;
        if (!rdy)
        begin
            res.status = STATUS_NOT_READY;
            return res;
        end
        if (reading_crc(k, hi, lo) != chk)
        begin
            res.status = STATUS_CRC_ERROR;
            return res;
        end
        res.status = STATUS_OK;
        raw = $signed({hi, lo});
        if (!k)
        begin
            acc = model_cfg.low_res ? raw * 4 - T_OFFSET : raw - T_OFFSET;
        end
        else if (model_cfg.low_res)
        begin
            acc = H_C3_LOWRES * raw + H_C2;
            acc = acc >>> 7;
            acc = acc * raw + H_ROUND;
            acc = (acc >>> 17) - H_OFFSET;
        end
        else
        begin
            acc = (H_C3_HIGHRES * raw) >>> 2;
            acc = acc + H_C2;
            acc = acc >>> 11;
            acc = acc * raw + H_ROUND;
            acc = (acc >>> 17) - H_OFFSET;
        end
        res.value = acc[15:0];
        return res;
    endfunction

    // start is left high; pause_sender or drain_pipeline lowers it
    task automatic send_reading(input logic k, input logic rdy, input logic [7:0] hi,
                                input logic [7:0] lo, input logic [7:0] chk);
        start        <= 1'b1;
        kind         <= k;
        sensor_ready <= rdy;
        data_high    <= hi;
        data_low     <= lo;
        check_byte   <= chk;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        expected_readings.push_back(convert_reading(k, rdy, hi, lo, chk));
    endtask

    task automatic send_good(input logic k, input logic [15:0] raw);
        send_reading(k, 1'b1, raw[15:8], raw[7:0], reading_crc(k, raw[15:8], raw[7:0]));
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles)
        begin
            kind         <= 1'($urandom);
            sensor_ready <= 1'($urandom);
            data_high    <= 8'($urandom);
            data_low     <= 8'($urandom);
            check_byte   <= 8'($urandom);
            @(posedge clk);
        end
    endtask

    task automatic drain_pipeline();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_readings.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input reg_index_t idx, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * idx);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_LOW_RES:  model_cfg.low_res  = data[0];
            REG_TEMP_CMD: model_cfg.temp_cmd = data[7:0];
            REG_HUM_CMD:  model_cfg.hum_cmd  = data[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic lr, input logic [7:0] tc, input logic [7:0] hc);
        drain_pipeline();
        apb_write(REG_LOW_RES, {31'd0, lr});
        apb_write(REG_TEMP_CMD, {24'd0, tc});
        apb_write(REG_HUM_CMD, {24'd0, hc});
    endtask

    task automatic send_random_reading();
        logic       k;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] good;
        int         pick;
        k    = 1'($urandom);
        hi   = 8'($urandom);
        lo   = 8'($urandom);
        if ($urandom_range(0, 7) == 0)
        begin
            hi = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            lo = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        good = reading_crc(k, hi, lo);
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            send_reading(k, 1'b1, hi, lo, good);
        end
        else if (pick < 85)
        begin
            send_reading(k, 1'b1, hi, lo, good ^ 8'($urandom_range(1, 255)));
        end
        else
        begin
            send_reading(k, 1'b0, hi, lo, $urandom_range(0, 1) ? good : 8'($urandom));
        end
    endtask

    task automatic test_reset_config();
        send_good(1'b0, 16'h0000);
        send_good(1'b0, 16'hFFFF);
        send_good(1'b0, 16'h7FFF);
        send_good(1'b0, 16'h8000);
        send_good(1'b1, 16'h0000);
        send_good(1'b1, 16'h0FFF);
        send_good(1'b1, 16'h7FFF);
        send_good(1'b1, 16'hFFFF);
    endtask

    task automatic test_not_ready();
        send_reading(1'b0, 1'b0, 8'h12, 8'h34, reading_crc(1'b0, 8'h12, 8'h34));
        send_reading(1'b1, 1'b0, 8'hFF, 8'hFF, 8'h00);
    endtask

    task automatic test_crc_mismatch();
        send_reading(1'b0, 1'b1, 8'h0A, 8'hBC, reading_crc(1'b0, 8'h0A, 8'hBC) ^ 8'h01);
        send_reading(1'b1, 1'b1, 8'h05, 8'h55, reading_crc(1'b1, 8'h05, 8'h55) ^ 8'h80);
    endtask

    task automatic test_low_res_commands();
        apply_config(1'b1, 8'hFF, 8'h00);
        send_good(1'b0, 16'h0FFF);
        send_good(1'b0, 16'hFFFF);
        send_good(1'b1, 16'h00FF);
        send_good(1'b1, 16'h8000);
        send_reading(1'b1, 1'b1, 8'h00, 8'h7F, reading_crc(1'b1, 8'h00, 8'h7F) ^ 8'hFF);
        send_reading(1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_random(input logic lr, input logic [7:0] tc, input logic [7:0] hc,
                               input int count);
        int sent;
        int burst;
        apply_config(lr, tc, hc);
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst && sent < count; j++)
            begin
                send_random_reading();
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                pause_sender($urandom_range(1, 12));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (expected_readings.size() == 0)
            begin
                $display("%0t: unexpected result value %h status %0d", $time, value, status);
                error_count++;
            end
            else
            begin
                reading_result_t exp_res;
                exp_res = expected_readings.pop_front();
                if (value !== exp_res.value)
                begin
                    $display("%0t: value expected %h actual %h", $time, exp_res.value, value);
                    error_count++;
                end
                if (status !== exp_res.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, exp_res.status,
                             status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done === 1'b1)
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("humidity_sensor_check_convert verification failed");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        start        <= 1'b0;
        kind         <= 1'b0;
        sensor_ready <= 1'b0;
        data_high    <= 8'h00;
        data_low     <= 8'h00;
        check_byte   <= 8'h00;
        stall_cycles <= 0;
        error_count  = 0;
        model_cfg.low_res  = 1'b0;
        model_cfg.temp_cmd = 8'd3;
        model_cfg.hum_cmd  = 8'd5;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_not_ready();
        test_crc_mismatch();
        test_low_res_commands();
        test_random(1'b0, 8'h03, 8'h05, 200);
        test_random(1'b1, 8'h00, 8'hFF, 200);
        test_random(1'b0, 8'hFF, 8'h00, 200);
        test_random(1'b1, 8'($urandom), 8'($urandom), 200);
        test_random(1'b0, 8'($urandom), 8'($urandom), 200);
        drain_pipeline();

        if (error_count == 0)
        begin
            $display("humidity_sensor_check_convert verification clean");
        end
        else
        begin
            $display("humidity_sensor_check_convert verification failed");
        end
        $finish;
    end

endmodule
